/* rtl/qlsr_pkg.sv */
package qlsr_pkg;

  localparam int BYTE_W     = 8;
  localparam int OPC_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 14;
  localparam int SEQ_W      = 8;
  localparam int TAG_HALF_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int TAG_SLOTS  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TAG_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_SECOND = 2'd1;

  localparam logic [BYTE_W-1:0] QUOTE_SINGLE = 8'd39;
  localparam logic [BYTE_W-1:0] QUOTE_DOUBLE = 8'd34;
  localparam logic [BYTE_W-1:0] LINE_FEED    = 8'd10;

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    RUN_NONE   = 2'd0,
    RUN_EMPTY  = 2'd1,
    RUN_REJECT = 2'd2,
    RUN_DONE   = 2'd3
  } run_status_e;

  // which result the datapath produces this cycle
  typedef enum logic [2:0] {
    RES_NONE,
    RES_WRITE,
    RES_READ,
    RES_NOP,
    RES_EMPTY,
    RES_REJECT,
    RES_DONE
  } res_e;

  typedef struct packed {
    res_e res;
    logic scan_init;
    logic scan_en;
    logic copy_init;
    logic copy_en;
  } cmd_t;

  typedef struct packed {
    logic in_empty;
    logic in_short;
    logic scan_fail;
    logic scan_hit;
    logic copy_last;
  } stat_t;

endpackage

/* rtl/qlsr_ctrl.sv */
module qlsr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [qlsr_pkg::OPC_W-1:0]    opcode_i,
  input  qlsr_pkg::stat_t               stat_i,
  output qlsr_pkg::cmd_t                cmd_o,
  output logic                          busy_o,
  output logic                          done_o
);
  import qlsr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COPY
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;
  logic   accept;

  assign accept = start && !busy_q;

  always_comb begin
    cmd_o   = '0;
    cmd_o.res = RES_NONE;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_WRITE: cmd_o.res = RES_WRITE;
            OP_READ:  cmd_o.res = RES_READ;
            OP_NOP:   cmd_o.res = RES_NOP;
            OP_RUN: begin
              if (stat_i.in_empty) begin
                cmd_o.res = RES_EMPTY;
              end else if (stat_i.in_short) begin
                cmd_o.res = RES_REJECT;
              end else begin
                cmd_o.scan_init = 1'b1;
                state_d = ST_SCAN;
              end
            end
            default: cmd_o.res = RES_NOP;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.scan_fail) begin
          cmd_o.res = RES_REJECT;
          state_d = ST_IDLE;
        end else if (stat_i.scan_hit) begin
          cmd_o.copy_init = 1'b1;
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd_o.copy_en = 1'b1;
        if (stat_i.copy_last) begin
          cmd_o.res = RES_DONE;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_d = (state_d != ST_IDLE);
  assign done_d = (cmd_o.res != RES_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

/* rtl/qlsr_dp.sv */
module qlsr_dp #(
  parameter int STORE_DEPTH  = 8192,
  parameter int PREFIX_BYTES = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  qlsr_pkg::cmd_t                     cmd_i,
  output qlsr_pkg::stat_t                    stat_o,
  input  logic [qlsr_pkg::BYTE_W-1:0]        data_byte_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [qlsr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qlsr_pkg::TAG_HALF_W-1:0]    cfg_data_i,
  output logic [qlsr_pkg::BYTE_W-1:0]        read_byte_o,
  output logic                               read_valid_o,
  output logic                               write_accepted_o,
  output logic [qlsr_pkg::STATUS_W-1:0]      run_status_o,
  output logic [qlsr_pkg::COUNT_W-1:0]       byte_count_o,
  output logic [qlsr_pkg::SEQ_W-1:0]         run_sequence_o
);
  import qlsr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(STORE_DEPTH);
  localparam logic [CW-1:0] SHORT_C  = CW'(PREFIX_BYTES);
  localparam logic [AW-1:0] PFX_C    = AW'(PREFIX_BYTES);
  localparam logic [AW-1:0] BODY_C   = AW'(PREFIX_BYTES + 1);

  logic [BYTE_W-1:0] in_mem  [STORE_DEPTH];
  logic [BYTE_W-1:0] out_mem [STORE_DEPTH];

  logic [BYTE_W-1:0]     in_rdata_q, out_rdata_q;
  logic [TAG_HALF_W-1:0] tag_first_q, tag_second_q;
  logic [BYTE_W-1:0]     tag_bytes [TAG_SLOTS];

  logic [CW-1:0]    in_count_q, in_count_d;
  logic [CW-1:0]    out_count_q, out_count_d;
  logic [AW-1:0]    read_head_q, read_head_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [CW-1:0]    scan_addr_q, scan_addr_d;
  logic [AW-1:0]    chk_addr_q;
  logic             chk_vld_q;
  logic [BYTE_W-1:0] quote_q;
  logic [AW-1:0]    close_q, body_q;
  logic [AW-1:0]    cp_idx_q, cp_idx_d;
  logic             cp_vld_q;

  logic              res_rvalid_q, res_rvalid_d;
  logic              res_wacc_q, res_wacc_d;
  run_status_e       res_status_q, res_status_d;
  logic [CW-1:0]     res_count_q, res_count_d;

  logic wr_ok, rd_ok, scan_issue, copy_issue;
  logic is_tag, is_open, in_body, tag_bad, open_bad, last, hit, fail, copy_last;
  logic [CW-1:0] produced;

  always_comb begin
    for (int k = 0; k < TAG_SLOTS; k++) begin
      tag_bytes[k] = '0;
    end
    for (int k = 0; k < 6; k++) begin
      tag_bytes[k]     = tag_first_q[8*k +: 8];
      tag_bytes[k + 6] = tag_second_q[8*k +: 8];
    end
  end

  assign wr_ok = (cmd_i.res == RES_WRITE) && (in_count_q != DEPTH_C);
  assign rd_ok = (cmd_i.res == RES_READ) && (out_count_q != '0);

  assign scan_issue = cmd_i.scan_en && (scan_addr_q < in_count_q);
  assign copy_issue = cmd_i.copy_en && (scan_addr_q <= CW'(close_q));

  // byte checks on the read data of the scan pipeline
  assign is_tag   = chk_addr_q < PFX_C;
  assign is_open  = chk_addr_q == PFX_C;
  assign in_body  = chk_addr_q > PFX_C;
  assign tag_bad  = is_tag && (in_rdata_q != tag_bytes[chk_addr_q[3:0]]);
  assign open_bad = is_open && (in_rdata_q != QUOTE_SINGLE) && (in_rdata_q != QUOTE_DOUBLE);
  assign hit      = chk_vld_q && in_body && (in_rdata_q == quote_q);
  assign last     = CW'(chk_addr_q) == (in_count_q - CW'(1));
  // body never exceeds STORE_DEPTH-PREFIX_BYTES-2 since the closing quote lies inside the store
  assign fail     = chk_vld_q && (tag_bad || open_bad || (last && !hit));

  assign copy_last = cp_vld_q && (cp_idx_q == body_q);
  assign produced  = CW'(body_q) + CW'(1);

  assign stat_o.in_empty  = (in_count_q == '0);
  assign stat_o.in_short  = (in_count_q <= SHORT_C);
  assign stat_o.scan_fail = fail;
  assign stat_o.scan_hit  = hit;
  assign stat_o.copy_last = copy_last;

  always_comb begin
    in_count_d  = in_count_q;
    out_count_d = out_count_q;
    read_head_d = read_head_q;
    seq_d       = seq_q;
    if (wr_ok) begin
      in_count_d = in_count_q + CW'(1);
    end
    if (rd_ok) begin
      out_count_d = out_count_q - CW'(1);
      read_head_d = read_head_q + AW'(1);
    end
    if (cmd_i.res == RES_DONE) begin
      in_count_d  = '0;
      out_count_d = produced;
      read_head_d = '0;
      seq_d       = seq_q + SEQ_W'(1);
    end

    if (cmd_i.scan_init) begin
      scan_addr_d = '0;
    end else if (cmd_i.copy_init) begin
      scan_addr_d = CW'(BODY_C);
    end else if (scan_issue || copy_issue) begin
      scan_addr_d = scan_addr_q + CW'(1);
    end else begin
      scan_addr_d = scan_addr_q;
    end

    if (cmd_i.copy_init) begin
      cp_idx_d = '0;
    end else if (cp_vld_q) begin
      cp_idx_d = cp_idx_q + AW'(1);
    end else begin
      cp_idx_d = cp_idx_q;
    end

    res_rvalid_d = rd_ok;
    res_wacc_d   = wr_ok;
    res_status_d = RUN_NONE;
    res_count_d  = '0;
    case (cmd_i.res)
      RES_WRITE:  res_count_d = in_count_d;
      RES_READ:   res_count_d = out_count_d;
      RES_EMPTY:  res_status_d = RUN_EMPTY;
      RES_REJECT: res_status_d = RUN_REJECT;
      RES_DONE: begin
        res_status_d = RUN_DONE;
        res_count_d  = produced;
      end
      default: res_count_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q   <= '0;
      out_count_q  <= '0;
      read_head_q  <= '0;
      seq_q        <= '0;
      tag_first_q  <= '0;
      tag_second_q <= '0;
      scan_addr_q  <= '0;
      chk_vld_q    <= 1'b0;
      cp_vld_q     <= 1'b0;
      cp_idx_q     <= '0;
      res_rvalid_q <= 1'b0;
      res_wacc_q   <= 1'b0;
      res_status_q <= RUN_NONE;
      res_count_q  <= '0;
    end else begin
      in_count_q  <= in_count_d;
      out_count_q <= out_count_d;
      read_head_q <= read_head_d;
      seq_q       <= seq_d;
      scan_addr_q <= scan_addr_d;
      chk_vld_q   <= scan_issue;
      cp_vld_q    <= copy_issue;
      cp_idx_q    <= cp_idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_TAG_FIRST) begin
          tag_first_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_TAG_SECOND) begin
          tag_second_q <= cfg_data_i;
        end
      end
      if (cmd_i.res != RES_NONE) begin
        res_rvalid_q <= res_rvalid_d;
        res_wacc_q   <= res_wacc_d;
        res_status_q <= res_status_d;
        res_count_q  <= res_count_d;
      end
    end
  end

  // stores and the scan pipeline payload
  always_ff @(posedge clk_i) begin
    in_rdata_q  <= in_mem[scan_addr_q[AW-1:0]];
    out_rdata_q <= out_mem[read_head_q];
    chk_addr_q  <= scan_addr_q[AW-1:0];
    if (wr_ok) begin
      in_mem[in_count_q[AW-1:0]] <= data_byte_i;
    end
    if (cp_vld_q) begin
      out_mem[cp_idx_q] <= copy_last ? LINE_FEED : in_rdata_q;
    end
    if (chk_vld_q && is_open) begin
      quote_q <= in_rdata_q;
    end
    if (cmd_i.copy_init) begin
      close_q <= chk_addr_q;
      body_q  <= chk_addr_q - BODY_C;
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign read_byte_o      = res_rvalid_q ? out_rdata_q : '0;
  assign read_valid_o     = res_rvalid_q;
  assign write_accepted_o = res_wacc_q;
  assign run_status_o     = res_status_q;
  assign byte_count_o     = COUNT_W'(res_count_q);
  assign run_sequence_o   = seq_q;

endmodule

/* rtl/quoted_literal_script_runner_top.sv */
// channel   | handshake                    | payload
// ----------+------------------------------+--------------------------------------------
// command   | start / busy                 | opcode_i, data_byte_i
// result    | done_o (one-cycle strobe)    | read_byte_o, read_valid_o, write_accepted_o,
//           |                              | run_status_o, byte_count_o, run_sequence_o
// config    | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// write, read and no-op: result in the cycle after the command, busy stays low, so one
// command per cycle. run: busy while the single read port of the input store walks it
// once to check up to the closing quote and once more to copy the body. empty or short
// input: result in the cycle after the command, busy stays low.
// asynchronous active-low reset, no clearing pass; the receiver cannot stall.
module quoted_literal_script_runner_top #(
  parameter int STORE_DEPTH  = 8192,
  parameter int PREFIX_BYTES = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [qlsr_pkg::OPC_W-1:0]         opcode_i,
  input  logic [qlsr_pkg::BYTE_W-1:0]        data_byte_i,
  output logic                               done_o,
  output logic [qlsr_pkg::BYTE_W-1:0]        read_byte_o,
  output logic                               read_valid_o,
  output logic                               write_accepted_o,
  output logic [qlsr_pkg::STATUS_W-1:0]      run_status_o,
  output logic [qlsr_pkg::COUNT_W-1:0]       byte_count_o,
  output logic [qlsr_pkg::SEQ_W-1:0]         run_sequence_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [qlsr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qlsr_pkg::TAG_HALF_W-1:0]    cfg_data_i
);
  import qlsr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  qlsr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  qlsr_dp #(
    .STORE_DEPTH  (STORE_DEPTH),
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .data_byte_i      (data_byte_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .read_byte_o      (read_byte_o),
    .read_valid_o     (read_valid_o),
    .write_accepted_o (write_accepted_o),
    .run_status_o     (run_status_o),
    .byte_count_o     (byte_count_o),
    .run_sequence_o   (run_sequence_o)
  );

endmodule

/* rtl/qlsr_checker.sv */
module qlsr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic [qlsr_pkg::OPC_W-1:0]         opcode_i,
  input logic                               done_o,
  input logic                               read_valid_o,
  input logic                               write_accepted_o,
  input logic [qlsr_pkg::STATUS_W-1:0]      run_status_o,
  input logic [qlsr_pkg::COUNT_W-1:0]       byte_count_o,
  input logic [qlsr_pkg::SEQ_W-1:0]         run_sequence_o
);
  import qlsr_pkg::*;

  // every transaction that is not a run answers in the next cycle
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && opcode_i != OP_RUN |=> done_o)
    else $error("no result after a single-cycle command");

  // a long run always ends with its result
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("run finished without a result");

  a_read_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && read_valid_o |-> run_status_o == RUN_NONE && !write_accepted_o)
    else $error("read result mixed with other flags");

  a_done_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && run_status_o == RUN_DONE |-> byte_count_o != '0)
    else $error("successful run produced no bytes");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && run_status_o == RUN_DONE |->
      run_sequence_o == SEQ_W'($past(run_sequence_o) + SEQ_W'(1)))
    else $error("sequence did not advance by one");

endmodule

bind quoted_literal_script_runner_top qlsr_checker u_qlsr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .opcode_i         (opcode_i),
  .done_o           (done_o),
  .read_valid_o     (read_valid_o),
  .write_accepted_o (write_accepted_o),
  .run_status_o     (run_status_o),
  .byte_count_o     (byte_count_o),
  .run_sequence_o   (run_sequence_o)
);
